/* rtl/core/svf_pkg.sv */
// shared types, constants and arithmetic helpers of the state-variable filter
package svf_pkg;

  // default parameter values
  localparam int unsigned CHANNELS_DEF     = 2;
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;

  // fixed field and datapath widths
  localparam int unsigned CHANNEL_WIDTH = 1;
  localparam int unsigned FREQ_WIDTH    = 17;
  localparam int unsigned DAMP_WIDTH    = 20;
  localparam int unsigned MODE_WIDTH    = 2;
  localparam int unsigned STATE_WIDTH   = 32;
  localparam int unsigned COEF_WIDTH    = DAMP_WIDTH + 1;             // signed view of coefs
  localparam int unsigned PROD_WIDTH    = COEF_WIDTH + STATE_WIDTH;   // 53
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned RND_WIDTH     = PROD_WIDTH - FRAC_BITS;     // 37
  localparam int unsigned SUM_WIDTH     = RND_WIDTH + 1;              // 38
  localparam int unsigned CFG_IDX_WIDTH = 2;
  localparam int unsigned CFG_DAT_WIDTH = DAMP_WIDTH;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FREQ = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DAMP = 2'd2;

  // filter modes
  localparam logic [MODE_WIDTH-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_LOW  = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_HIGH = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_BAND = 2'd3;

  // register reset values
  localparam logic [FREQ_WIDTH-1:0] FREQ_RESET = 17'd89719;
  localparam logic [DAMP_WIDTH-1:0] DAMP_RESET = 20'd92682;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_FB,
    ST_MUL_DB,
    ST_HIGH,
    ST_MUL_FH,
    ST_BAND
  } state_e;

  // round half up and drop the Q.16 fraction
  function automatic logic signed [RND_WIDTH-1:0] rnd16(input logic signed [PROD_WIDTH-1:0] p);
    logic signed [PROD_WIDTH-1:0] r;
    r = p + PROD_WIDTH'(32768);
    return RND_WIDTH'(r >>> FRAC_BITS);
  endfunction

  // clamp to the 32-bit state range
  function automatic logic signed [STATE_WIDTH-1:0] sat32(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] lo;
    hi = SUM_WIDTH'(signed'(32'sh7fff_ffff));
    lo = SUM_WIDTH'(signed'(32'sh8000_0000));
    if (v > hi) begin
      return STATE_WIDTH'(hi);
    end else if (v < lo) begin
      return STATE_WIDTH'(lo);
    end
    return STATE_WIDTH'(v);
  endfunction

endpackage

/* rtl/core/state_variable_filter_top.sv */
// chamberlin state-variable filter with one shared multiplier and per-channel state
// result path: filtered requests step through MUL_FB, MUL_DB, HIGH, MUL_FH and BAND, bypassed
//   ones go straight to the output register; no new request is taken until the three multiplies
//   on a single 21x32 multiplier under the sequencer end; bypass requests every cycle if output drains
// reset: asynchronous active low, clears integrators and restores register defaults
// the next request is taken while a finished result still waits, if the output drains in time
module state_variable_filter_top #(
  parameter int unsigned CHANNELS     = svf_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_WIDTH = svf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration writes
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [svf_pkg::CFG_IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [svf_pkg::CFG_DAT_WIDTH-1:0]       cfg_data_i,
  // sample requests
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [svf_pkg::CHANNEL_WIDTH-1:0]       channel_i,
  input  logic signed [SAMPLE_WIDTH-1:0]          sample_in_i,
  // filtered results
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]          sample_out_o
);

  localparam int unsigned SW       = svf_pkg::STATE_WIDTH;
  localparam int unsigned ChIdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // output clamp limits in the 32-bit state domain
  localparam logic signed [SW-1:0] OutMax = 32'sh7fff_ffff >>> (SW - SAMPLE_WIDTH);
  localparam logic signed [SW-1:0] OutMin = ~OutMax;

  // configuration registers
  logic [svf_pkg::MODE_WIDTH-1:0] mode_q;
  logic [svf_pkg::FREQ_WIDTH-1:0] freq_q;
  logic [svf_pkg::DAMP_WIDTH-1:0] damp_q;

  // per-channel integrators
  logic signed [SW-1:0] low_mem_q  [CHANNELS];
  logic signed [SW-1:0] band_mem_q [CHANNELS];

  // sequencer and working registers
  svf_pkg::state_e state_q, state_d;
  logic [ChIdxW-1:0]                      ch_q;
  logic [svf_pkg::MODE_WIDTH-1:0]         wmode_q;
  logic signed [SW-1:0]                   x_q;
  logic signed [SW-1:0]                   low_q, low_d;
  logic signed [SW-1:0]                   band_q;
  logic signed [SW-1:0]                   high_q, high_d;
  logic signed [svf_pkg::PROD_WIDTH-1:0]  prod_q;
  logic                                   out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]         out_q;

  // request decode
  logic                                   in_fire;
  logic                                   bypass;
  logic [ChIdxW-1:0]                      ch_idx;
  logic signed [SW-1:0]                   x_ext;

  // shared multiplier
  logic signed [svf_pkg::COEF_WIDTH-1:0]  mul_a;
  logic signed [SW-1:0]                   mul_b;
  logic signed [svf_pkg::PROD_WIDTH-1:0]  prod_d;
  logic signed [svf_pkg::RND_WIDTH-1:0]   prod_rnd;

  // finishing step
  logic signed [SW-1:0]                   band_new;
  logic signed [SW-1:0]                   res_pick;
  logic signed [SAMPLE_WIDTH-1:0]         res_sat;
  logic                                   done;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == svf_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  assign ch_idx = ChIdxW'(channel_i);
  assign x_ext  = SW'(sample_in_i);
  // off mode or an out-of-range channel passes the sample straight through
  assign bypass = (mode_q == svf_pkg::MODE_OFF) || (32'(channel_i) >= CHANNELS);

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= svf_pkg::MODE_OFF;
      freq_q <= svf_pkg::FREQ_RESET;
      damp_q <= svf_pkg::DAMP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        svf_pkg::REG_MODE: mode_q <= cfg_data_i[svf_pkg::MODE_WIDTH-1:0];
        svf_pkg::REG_FREQ: freq_q <= cfg_data_i[svf_pkg::FREQ_WIDTH-1:0];
        svf_pkg::REG_DAMP: damp_q <= cfg_data_i;
        default: ;  // unknown index is dropped
      endcase
    end
  end

  // operand selection for the shared multiplier: F*band, D*band, then F*high
  always_comb begin
    case (state_q)
      svf_pkg::ST_MUL_DB: begin
        mul_a = svf_pkg::COEF_WIDTH'(damp_q);
        mul_b = band_q;
      end
      svf_pkg::ST_MUL_FH: begin
        mul_a = svf_pkg::COEF_WIDTH'(freq_q);
        mul_b = high_q;
      end
      default: begin
        mul_a = svf_pkg::COEF_WIDTH'(freq_q);
        mul_b = band_q;
      end
    endcase
  end

  assign prod_d   = svf_pkg::PROD_WIDTH'(mul_a) * svf_pkg::PROD_WIDTH'(mul_b);
  assign prod_rnd = svf_pkg::rnd16(prod_q);

  // low := low + rnd(F*band), formed while D*band is being multiplied
  assign low_d = svf_pkg::sat32(svf_pkg::SUM_WIDTH'(low_q) + svf_pkg::SUM_WIDTH'(prod_rnd));
  // high := x - low - rnd(D*band)
  assign high_d = svf_pkg::sat32(svf_pkg::SUM_WIDTH'(x_q) - svf_pkg::SUM_WIDTH'(low_q)
                                 - svf_pkg::SUM_WIDTH'(prod_rnd));
  // band := band + rnd(F*high)
  assign band_new = svf_pkg::sat32(svf_pkg::SUM_WIDTH'(band_q) + svf_pkg::SUM_WIDTH'(prod_rnd));

  always_comb begin
    case (wmode_q)
      svf_pkg::MODE_LOW:  res_pick = low_q;
      svf_pkg::MODE_HIGH: res_pick = high_q;
      default:            res_pick = band_new;
    endcase
    if (res_pick > OutMax) begin
      res_sat = SAMPLE_WIDTH'(OutMax);
    end else if (res_pick < OutMin) begin
      res_sat = SAMPLE_WIDTH'(OutMin);
    end else begin
      res_sat = SAMPLE_WIDTH'(res_pick);
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    done    = 1'b0;
    case (state_q)
      svf_pkg::ST_IDLE: begin
        if (in_fire && !bypass) begin
          state_d = svf_pkg::ST_MUL_FB;
        end
      end
      svf_pkg::ST_MUL_FB: state_d = svf_pkg::ST_MUL_DB;
      svf_pkg::ST_MUL_DB: state_d = svf_pkg::ST_HIGH;
      svf_pkg::ST_HIGH:   state_d = svf_pkg::ST_MUL_FH;
      svf_pkg::ST_MUL_FH: state_d = svf_pkg::ST_BAND;
      svf_pkg::ST_BAND: begin
        done    = 1'b1;
        state_d = svf_pkg::ST_IDLE;
      end
      default: state_d = svf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && !bypass) begin
      ch_q    <= ch_idx;
      wmode_q <= mode_q;
      x_q     <= x_ext;
      low_q   <= low_mem_q[ch_idx];
      band_q  <= band_mem_q[ch_idx];
    end
    if ((state_q == svf_pkg::ST_MUL_FB) || (state_q == svf_pkg::ST_MUL_DB)
        || (state_q == svf_pkg::ST_MUL_FH)) begin
      prod_q <= prod_d;
    end
    if (state_q == svf_pkg::ST_MUL_DB) begin
      low_q <= low_d;
    end
    if (state_q == svf_pkg::ST_HIGH) begin
      high_q <= high_d;
    end
  end

  // integrator state, written back at the end of a filtered request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        low_mem_q[i]  <= '0;
        band_mem_q[i] <= '0;
      end
    end else if (done) begin
      low_mem_q[ch_q]  <= low_q;
      band_mem_q[ch_q] <= band_new;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_fire && bypass) || done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && bypass) begin
      out_q <= sample_in_i;
    end else if (done) begin
      out_q <= res_sat;
    end
  end

endmodule

/* dv/tb.sv */
// testbench for the state-variable filter: scoreboard class, request drivers and regression
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SW = svf_pkg::SAMPLE_WIDTH_DEF;

  // the one register index that the block does not implement
  localparam logic [svf_pkg::CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  // cycles without any accepted request before the run is declared hung
  localparam int QUIET_LIMIT = 2000;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;

  // per-channel filter state and the results still owed by the block
  class filter_scoreboard;
    logic [svf_pkg::MODE_WIDTH-1:0]         mode;
    logic [svf_pkg::FREQ_WIDTH-1:0]         freq;
    logic [svf_pkg::DAMP_WIDTH-1:0]         damp;
    logic signed [svf_pkg::STATE_WIDTH-1:0] low_int [svf_pkg::CHANNELS_DEF];
    logic signed [svf_pkg::STATE_WIDTH-1:0] band_int [svf_pkg::CHANNELS_DEF];
    logic [SW-1:0]                          expected_out [$];
    int                                     errors;

    function new();
      mode   = svf_pkg::MODE_OFF;
      freq   = svf_pkg::FREQ_RESET;
      damp   = svf_pkg::DAMP_RESET;
      errors = 0;
      foreach (low_int[i]) begin
        low_int[i]  = '0;
        band_int[i] = '0;
      end
    endfunction

    function longint round_q16(longint p);
      return (p + 64'sd32768) >>> 16;
    endfunction

    function longint clamp_to(longint v, int bits);
      longint top;
      longint bot;
      top = (longint'(1) <<< (bits - 1)) - 1;
      bot = -top - 1;
      if (v > top) return top;
      if (v < bot) return bot;
      return v;
    endfunction

    function void write_reg(logic [svf_pkg::CFG_IDX_WIDTH-1:0] idx,
                            logic [svf_pkg::CFG_DAT_WIDTH-1:0] data);
      case (idx)
        svf_pkg::REG_MODE: mode = data[svf_pkg::MODE_WIDTH-1:0];
        svf_pkg::REG_FREQ: freq = data[svf_pkg::FREQ_WIDTH-1:0];
        svf_pkg::REG_DAMP: damp = data[svf_pkg::DAMP_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // one integrator step of the selected channel
    function logic [SW-1:0] filter_sample(logic [svf_pkg::CHANNEL_WIDTH-1:0] ch,
                                          logic signed [SW-1:0] x);
      longint lo;
      longint bd;
      longint hi;
      longint res;
      if (mode == svf_pkg::MODE_OFF) return x;
      lo = low_int[ch];
      bd = band_int[ch];
      lo = clamp_to(lo + round_q16(longint'(freq) * bd), svf_pkg::STATE_WIDTH);
      hi = clamp_to(longint'(x) - lo - round_q16(longint'(damp) * bd),
                    svf_pkg::STATE_WIDTH);
      bd = clamp_to(bd + round_q16(longint'(freq) * hi), svf_pkg::STATE_WIDTH);
      low_int[ch]  = lo[svf_pkg::STATE_WIDTH-1:0];
      band_int[ch] = bd[svf_pkg::STATE_WIDTH-1:0];
      case (mode)
        svf_pkg::MODE_LOW:  res = lo;
        svf_pkg::MODE_HIGH: res = hi;
        default:            res = bd;
      endcase
      res = clamp_to(res, SW);
      return res[SW-1:0];
    endfunction

    function void note_sample(logic [svf_pkg::CHANNEL_WIDTH-1:0] ch,
                              logic signed [SW-1:0] x);
      expected_out.push_back(filter_sample(ch, x));
    endfunction

    function void check_output(logic [SW-1:0] y);
      logic [SW-1:0] exp_y;
      if (expected_out.size() == 0) begin
        $error("sample_out: no result expected, got %0d", $signed(y));
        errors++;
      end else begin
        exp_y = expected_out.pop_front();
        if (exp_y !== y) begin
          $error("sample_out: expected %0d, got %0d", $signed(exp_y), $signed(y));
          errors++;
        end
      end
    endfunction
  endclass

  // block ports; the inputs driven here are known from time zero
  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [svf_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i = '0;
  logic [svf_pkg::CFG_DAT_WIDTH-1:0] cfg_data_i  = '0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_ready_o;
  logic [svf_pkg::CHANNEL_WIDTH-1:0] channel_i   = '0;
  logic signed [SW-1:0]              sample_in_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [SW-1:0]              sample_out_o;

  filter_scoreboard sb;

  // idling odds in percent, changed per phase by the sequence
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // long hold-off asked of the receiver process
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  state_variable_filter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshakes are sampled at the edge, before any flop of the block updates
  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    if (in_valid_i && in_ready_o) sb.note_sample(channel_i, sample_in_i);
    if (out_valid_o && out_ready_i) sb.check_output(sample_out_o);
  end

  // hang detection: any handshake on the config, request or result side clears the count
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("state_variable_filter_top regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one register write; leaves the channel idle at a fresh edge
  task automatic cfg_write(input logic [svf_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [svf_pkg::CFG_DAT_WIDTH-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one sample request; valid stays high afterwards so requests can run back to back
  task automatic send_sample(input logic [svf_pkg::CHANNEL_WIDTH-1:0] ch,
                             input logic signed [SW-1:0] x);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    sample_in_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender pauses until the block has returned every owed result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_out.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SW'($signed($urandom_range(511)) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  // random mode and coefficients with the extremes mixed in; spare upper bits carry noise
  task automatic random_settings();
    logic [svf_pkg::CFG_DAT_WIDTH-1:0] d;
    d = svf_pkg::CFG_DAT_WIDTH'($urandom);
    d[svf_pkg::MODE_WIDTH-1:0] = svf_pkg::MODE_WIDTH'($urandom_range(3));
    cfg_write(svf_pkg::REG_MODE, d);
    d = svf_pkg::CFG_DAT_WIDTH'($urandom);
    case ($urandom_range(7))
      0:       d[svf_pkg::FREQ_WIDTH-1:0] = '0;
      1:       d[svf_pkg::FREQ_WIDTH-1:0] = '1;
      2, 3:    ;
      default: d[svf_pkg::FREQ_WIDTH-1:0] = svf_pkg::FREQ_WIDTH'($urandom_range(40000, 200));
    endcase
    cfg_write(svf_pkg::REG_FREQ, d);
    case ($urandom_range(9))
      0:       d = '0;
      1:       d = '1;
      2:       d = 20'd6553;
      3:       d = 20'd655360;
      default: d = svf_pkg::CFG_DAT_WIDTH'($urandom_range(655360, 6553));
    endcase
    cfg_write(svf_pkg::REG_DAMP, d);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through at the reset settings, sample extremes on both channels
    send_sample(1'b0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b0, '0);
    send_sample(1'b1, '1);
    drain_results();

    // lowpass, fastest cutoff and no damping: integrators run into saturation
    cfg_write(svf_pkg::REG_MODE, svf_pkg::CFG_DAT_WIDTH'(svf_pkg::MODE_LOW));
    cfg_write(svf_pkg::REG_FREQ, svf_pkg::CFG_DAT_WIDTH'({svf_pkg::FREQ_WIDTH{1'b1}}));
    cfg_write(svf_pkg::REG_DAMP, '0);
    repeat (4) send_sample(1'b0, SAMPLE_MAX);
    repeat (3) send_sample(1'b1, SAMPLE_MIN);
    drain_results();

    // highpass from the saturated state
    cfg_write(svf_pkg::REG_MODE, svf_pkg::CFG_DAT_WIDTH'(svf_pkg::MODE_HIGH));
    send_sample(1'b0, SAMPLE_MIN);
    send_sample(1'b1, SAMPLE_MAX);
    send_sample(1'b0, '0);
    send_sample(1'b1, '1);
    drain_results();

    // bandpass, frozen integrators but widest damping
    cfg_write(svf_pkg::REG_MODE, svf_pkg::CFG_DAT_WIDTH'(svf_pkg::MODE_BAND));
    cfg_write(svf_pkg::REG_FREQ, '0);
    cfg_write(svf_pkg::REG_DAMP, '1);
    send_sample(1'b0, SAMPLE_MAX);
    send_sample(1'b1, SAMPLE_MIN);
    send_sample(1'b1, '0);
    drain_results();

    // unknown index is dropped, oversized data is cut to the register width
    cfg_write(REG_UNUSED, '1);
    cfg_write(svf_pkg::REG_MODE, '1);
    cfg_write(svf_pkg::REG_FREQ, '1);
    send_sample(1'b0, '1);
    send_sample(1'b1, SAMPLE_MAX);
    send_sample(1'b0, SAMPLE_MIN);
    drain_results();

    // off again with live state: state must survive untouched
    cfg_write(svf_pkg::REG_MODE,
              {{(svf_pkg::CFG_DAT_WIDTH-svf_pkg::MODE_WIDTH){1'b1}}, svf_pkg::MODE_OFF});
    send_sample(1'b0, SAMPLE_MIN);
    send_sample(1'b1, SAMPLE_MAX);

    // random part: four idling phases, three coefficient sets each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 80; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        drain_results();
        random_settings();
        // receiver holds off while requests keep coming, so the input backs up
        if (ph == 0 && seg == 0) hold_request = 1'b1;
        for (int n = 0; n < 36; n++) begin
          send_sample(svf_pkg::CHANNEL_WIDTH'($urandom_range(1)), pick_sample());
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_out.size() == 0) begin
      $display("state_variable_filter_top regression: pass");
    end else begin
      $display("state_variable_filter_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/svf_pkg.sv
rtl/core/state_variable_filter_top.sv
dv/tb.sv
